[rtl/fzsh_pkg.sv]
// ----------------------------------------------------------------------------
// fzsh_pkg
// Shared constants and the fixed zone table of the stepped fan curve.
// ----------------------------------------------------------------------------
`default_nettype none

package fzsh_pkg;

   localparam int unsigned RAW_W    = 13;
   localparam int unsigned TEMP_W   = 11;
   localparam int unsigned SPEED_W  = 8;
   localparam int unsigned ZONE_W   = 4;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned IVAL_W   = 7;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 9;

   localparam logic [RAW_W:0] KELVIN_OFFSET = 14'd2732;
   // floor(n/10) == (n * 6554) >> 16 for every n below 8192
   localparam logic [12:0] RECIP_TEN = 13'd6554;

   localparam logic [STATUS_W-1:0] STATUS_SET     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_HELD    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TEMP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TEMP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HYST      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_IVAL = 2'd3;

   function automatic logic [7:0] zone_thresh(input logic [ZONE_W-1:0] idx);
      logic [7:0] r;
      case (idx)
         4'd0:    r = 8'd45;
         4'd1:    r = 8'd50;
         4'd2:    r = 8'd55;
         4'd3:    r = 8'd60;
         4'd4:    r = 8'd65;
         4'd5:    r = 8'd70;
         4'd6:    r = 8'd85;
         4'd7:    r = 8'd100;
         4'd8:    r = 8'd105;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   function automatic logic [SPEED_W-1:0] zone_speed(input logic [ZONE_W-1:0] idx);
      logic [SPEED_W-1:0] r;
      case (idx)
         4'd0:    r = 8'd0;
         4'd1:    r = 8'd80;
         4'd2:    r = 8'd100;
         4'd3:    r = 8'd110;
         4'd4:    r = 8'd130;
         4'd5:    r = 8'd140;
         4'd6:    r = 8'd160;
         4'd7:    r = 8'd190;
         4'd8:    r = 8'd210;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] zone_sleep(input logic [ZONE_W-1:0] idx);
      logic [2:0] r;
      case (idx)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4: r = 3'd1;
         4'd5:    r = 3'd2;
         4'd6:    r = 3'd3;
         4'd7:    r = 3'd5;
         4'd8:    r = 3'd7;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/fan_zone_speed_hysteresis_core.sv]
// ----------------------------------------------------------------------------
// fan_zone_speed_hysteresis_core
// Converts a thermal reading to Celsius, picks a fan zone with cooling
// hysteresis and reports status, speed, zone and the next poll interval.
// ----------------------------------------------------------------------------
// The accepted req beat is registered in the input register and its result in the
// result register, which drives rsp_valid; a result stall can hold it in between.
// Throughput: one reading per cycle while rsp_stall is low; an input register and a
// result register with a single pass of compare/lookup logic between them.
// Reset: zone and speed state cleared, config registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_zone_speed_hysteresis_core #(
   parameter int unsigned ZONE_COUNT = 9
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 csr_write,
   input  wire logic [fzsh_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [fzsh_pkg::CSR_DATA_W-1:0]      csr_wdata,

   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [fzsh_pkg::RAW_W-1:0]           req_raw_reading,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [fzsh_pkg::STATUS_W-1:0]             rsp_result_status,
   output logic [fzsh_pkg::SPEED_W-1:0]              rsp_fan_speed,
   output logic [fzsh_pkg::ZONE_W-1:0]               rsp_zone_index,
   output logic signed [fzsh_pkg::TEMP_W-1:0]        rsp_temperature_c,
   output logic [fzsh_pkg::IVAL_W-1:0]               rsp_next_interval_s
);

   localparam logic [fzsh_pkg::ZONE_W-1:0] TOP_ZONE = fzsh_pkg::ZONE_W'(ZONE_COUNT - 1);

   // config
   logic signed [7:0] min_temp_ff;
   logic signed [8:0] max_temp_ff;
   logic [3:0]        hyst_ff;
   logic [5:0]        base_ival_ff;

   // state
   logic [fzsh_pkg::ZONE_W-1:0]  last_zone_ff, last_zone_in;
   logic [fzsh_pkg::SPEED_W-1:0] speed_ff, speed_in;

   // input stage
   logic                       s0_valid_ff;
   logic [fzsh_pkg::RAW_W-1:0] s0_raw_ff;
   logic                       advance;

   // result stage
   logic                                rsp_valid_ff;
   logic [fzsh_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic [fzsh_pkg::SPEED_W-1:0]        fan_speed_ff;
   logic [fzsh_pkg::ZONE_W-1:0]         zone_ff, zone_in;
   logic signed [fzsh_pkg::TEMP_W-1:0]  temp_ff, temp_in;
   logic [fzsh_pkg::IVAL_W-1:0]         ival_ff, ival_in;

   // datapath
   logic signed [fzsh_pkg::RAW_W:0] diff;
   logic [fzsh_pkg::RAW_W-1:0]      mag;
   logic [25:0]                     prod;
   logic [9:0]                      quot;
   logic signed [11:0]              t_ext;
   logic signed [11:0]              min_ext;
   logic signed [11:0]              max_ext;
   logic signed [11:0]              top_thr;
   logic signed [11:0]              sel_thr;
   logic [fzsh_pkg::ZONE_W-1:0]     sel;
   logic                            keep;

   assign advance   = s0_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s0_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_temp_ff  <= 8'sd0;
         max_temp_ff  <= 9'sd110;
         hyst_ff      <= 4'd3;
         base_ival_ff <= 6'd10;
      end else if (csr_write) begin
         unique case (csr_index)
            fzsh_pkg::CSR_MIN_TEMP:  min_temp_ff  <= csr_wdata[7:0];
            fzsh_pkg::CSR_MAX_TEMP:  max_temp_ff  <= csr_wdata[8:0];
            fzsh_pkg::CSR_HYST:      hyst_ff      <= csr_wdata[3:0];
            fzsh_pkg::CSR_BASE_IVAL: base_ival_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // Celsius = (raw - 2732) / 10, toward zero, via reciprocal on the magnitude
   always_comb begin
      diff    = $signed({1'b0, s0_raw_ff}) - $signed(fzsh_pkg::KELVIN_OFFSET);
      mag     = diff[fzsh_pkg::RAW_W] ? fzsh_pkg::RAW_W'(-diff) : diff[fzsh_pkg::RAW_W-1:0];
      prod    = 26'(mag) * 26'(fzsh_pkg::RECIP_TEN);
      quot    = prod[25:16];
      temp_in = diff[fzsh_pkg::RAW_W] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      t_ext   = 12'(temp_in);
      min_ext = 12'(min_temp_ff);
      max_ext = 12'(max_temp_ff);
      top_thr = $signed({4'd0, fzsh_pkg::zone_thresh(TOP_ZONE)});
   end

   always_comb begin
      sel = TOP_ZONE;
      for (int i = ZONE_COUNT - 2; i >= 0; i--) begin
         if (t_ext < $signed({4'd0, fzsh_pkg::zone_thresh(fzsh_pkg::ZONE_W'(i))})) begin
            sel = fzsh_pkg::ZONE_W'(i);
         end
      end
      sel_thr = $signed({4'd0, fzsh_pkg::zone_thresh(sel)});
      keep    = (sel < last_zone_ff) && (t_ext > (sel_thr - $signed({8'd0, hyst_ff})));
   end

   always_comb begin
      last_zone_in = last_zone_ff;
      speed_in     = speed_ff;
      zone_in      = '0;
      if (t_ext > max_ext || t_ext < min_ext) begin
         status_in = fzsh_pkg::STATUS_INVALID;
         ival_in   = 7'(base_ival_ff);
      end else if (t_ext >= top_thr) begin
         status_in = fzsh_pkg::STATUS_HELD;
         ival_in   = 7'(base_ival_ff) + 7'(fzsh_pkg::zone_sleep('0));
      end else begin
         status_in = fzsh_pkg::STATUS_SET;
         zone_in   = sel;
         ival_in   = 7'(base_ival_ff) + 7'(fzsh_pkg::zone_sleep(sel));
         if (keep) begin
            speed_in = fzsh_pkg::zone_speed(last_zone_ff);
         end else begin
            speed_in     = fzsh_pkg::zone_speed(sel);
            last_zone_in = sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_zone_ff <= '0;
         speed_ff     <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            s0_valid_ff <= 1'b1;
         end else if (advance) begin
            s0_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            last_zone_ff <= last_zone_in;
            speed_ff     <= speed_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s0_raw_ff <= req_raw_reading;
      end
      if (advance) begin
         status_ff    <= status_in;
         fan_speed_ff <= speed_in;
         zone_ff      <= zone_in;
         temp_ff      <= temp_in;
         ival_ff      <= ival_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_status   = status_ff;
   assign rsp_fan_speed       = fan_speed_ff;
   assign rsp_zone_index      = zone_ff;
   assign rsp_temperature_c   = temp_ff;
   assign rsp_next_interval_s = ival_ff;

`ifndef ASSERT_OFF
   a_last_zone_range: assert property (@(posedge clock) disable iff (reset)
      32'(last_zone_ff) < ZONE_COUNT)
      else $error("last zone out of range");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s0_valid_ff && rsp_valid_ff)
      else $error("input stalled with free pipeline");

   a_invalid_keeps_state: assert property (@(posedge clock) disable iff (reset)
      advance && status_in != fzsh_pkg::STATUS_SET
      |=> $stable(last_zone_ff) && $stable(speed_ff))
      else $error("state changed on invalid or held reading");

   a_invalid_zone_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != fzsh_pkg::STATUS_SET |-> zone_ff == '0)
      else $error("zone reported without search");

   a_speed_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> fan_speed_ff == speed_ff)
      else $error("reported speed differs from state");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// fan_zone_speed_hysteresis_core testbench
// Sends thermal readings through the valid/stall request channel and checks
// every result beat against an in-bench prediction of the zone search,
// cooling hysteresis and poll interval. Covers directed edge readings, several
// register settings, random temperature walks, burst gaps and result stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_TAIL  = 4;
   localparam int CYCLE_LIMIT = 100000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [fzsh_pkg::STATUS_W-1:0] status;
      logic [fzsh_pkg::SPEED_W-1:0]  speed;
      logic [fzsh_pkg::ZONE_W-1:0]   zone;
      logic [fzsh_pkg::TEMP_W-1:0]   temp_c;
      logic [fzsh_pkg::IVAL_W-1:0]   interval;
   } fan_result_type;

   typedef enum int {RSP_READY, RSP_RANDOM, RSP_PATTERN} rsp_mode_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_write = 1'b0;
   logic [fzsh_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [fzsh_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [fzsh_pkg::RAW_W-1:0]      req_raw_reading = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [fzsh_pkg::STATUS_W-1:0]   rsp_result_status;
   logic [fzsh_pkg::SPEED_W-1:0]    rsp_fan_speed;
   logic [fzsh_pkg::ZONE_W-1:0]     rsp_zone_index;
   logic signed [fzsh_pkg::TEMP_W-1:0] rsp_temperature_c;
   logic [fzsh_pkg::IVAL_W-1:0]     rsp_next_interval_s;

   // fan curve table: threshold in C, drive level, extra sleep
   int zone_limit_c [0:8] = '{45, 50, 55, 60, 65, 70, 85, 100, 105};
   int zone_drive   [0:8] = '{0, 80, 100, 110, 130, 140, 160, 190, 210};
   int zone_sleep_s [0:8] = '{1, 1, 1, 1, 1, 2, 3, 5, 7};

   // predicted block state and registers
   int valid_lo_c = 0;
   int valid_hi_c = 110;
   int hyst_c     = 3;
   int base_s     = 10;
   int adopted_zone = 0;
   int drive_now    = 0;

   fan_result_type pending_results [$];
   int mismatches      = 0;
   int readings_sent   = 0;
   int results_checked = 0;
   int settings_applied = 0;
   int cycle_count     = 0;

   rsp_mode_type rsp_mode = RSP_READY;
   bit        sender_gaps = 1'b0;
   int        burst_left = 0;
   int        holds_asked = 0;
   int        holds_served = 0;
   int        hold_left = 0;
   logic [7:0] stall_pattern = 8'b0110_0101;
   int        walk_c = 40;
   int        drift = 1;

   fan_zone_speed_hysteresis_core u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_raw_reading     (req_raw_reading),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_status   (rsp_result_status),
      .rsp_fan_speed       (rsp_fan_speed),
      .rsp_zone_index      (rsp_zone_index),
      .rsp_temperature_c   (rsp_temperature_c),
      .rsp_next_interval_s (rsp_next_interval_s)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("fan_zone_speed_hysteresis_core verification failed");
         $finish;
      end
   end

   // zone search with cooling hysteresis; updates the predicted state
   function automatic fan_result_type predict_fan_result(
      input logic [fzsh_pkg::RAW_W-1:0] raw);
      int t;
      int z;
      fan_result_type r;
      t = (int'(raw) - 2732) / 10;
      r.temp_c = t[fzsh_pkg::TEMP_W-1:0];
      r.zone = '0;
      if (t > valid_hi_c || t < valid_lo_c) begin
         r.status = fzsh_pkg::STATUS_INVALID;
         r.interval = fzsh_pkg::IVAL_W'(base_s);
      end else if (t >= zone_limit_c[8]) begin
         r.status = fzsh_pkg::STATUS_HELD;
         r.interval = fzsh_pkg::IVAL_W'(base_s + zone_sleep_s[0]);
      end else begin
         z = 0;
         while (z < 8 && t >= zone_limit_c[z])
            z++;
         if (z < adopted_zone && t > zone_limit_c[z] - hyst_c) begin
            drive_now = zone_drive[adopted_zone];
         end else begin
            drive_now = zone_drive[z];
            adopted_zone = z;
         end
         r.status = fzsh_pkg::STATUS_SET;
         r.zone = fzsh_pkg::ZONE_W'(z);
         r.interval = fzsh_pkg::IVAL_W'(base_s + zone_sleep_s[z]);
      end
      r.speed = fzsh_pkg::SPEED_W'(drive_now);
      return r;
   endfunction

   // reading in tenths of a kelvin that converts to the given Celsius value
   function automatic logic [fzsh_pkg::RAW_W-1:0] raw_for_celsius(input int t);
      int raw;
      if (t >= 0)
         raw = 2732 + 10 * t + int'($urandom_range(0, 9));
      else
         raw = 2732 + 10 * t - int'($urandom_range(0, 9));
      if (raw < 0)
         raw = 0;
      if (raw > 8191)
         raw = 8191;
      return fzsh_pkg::RAW_W'(raw);
   endfunction

   task automatic send_reading(input logic [fzsh_pkg::RAW_W-1:0] raw);
      if (sender_gaps && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0)
         burst_left--;
      req_valid <= 1'b1;
      req_raw_reading <= raw;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_fan_result(raw));
      readings_sent++;
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic write_limits(input int lo, input int hi, input int hyst, input int base);
      logic [fzsh_pkg::CSR_IDX_W-1:0]  idx;
      logic [fzsh_pkg::CSR_DATA_W-1:0] d;
      logic [fzsh_pkg::CSR_DATA_W-1:0] lo_bits;
      logic [fzsh_pkg::CSR_DATA_W-1:0] hi_bits;
      wait_all_results();
      lo_bits = fzsh_pkg::CSR_DATA_W'(lo);
      hi_bits = fzsh_pkg::CSR_DATA_W'(hi);
      for (int k = 0; k < 4; k++) begin
         case (k)
            0: begin idx = fzsh_pkg::CSR_MIN_TEMP;  d = lo_bits; end
            1: begin idx = fzsh_pkg::CSR_MAX_TEMP;  d = hi_bits; end
            2: begin idx = fzsh_pkg::CSR_HYST;      d = fzsh_pkg::CSR_DATA_W'(hyst); end
            default: begin
               idx = fzsh_pkg::CSR_BASE_IVAL;
               d = fzsh_pkg::CSR_DATA_W'(base);
            end
         endcase
         csr_write <= 1'b1;
         csr_index <= idx;
         csr_wdata <= d;
         @(posedge clock);
      end
      csr_write <= 1'b0;
      valid_lo_c = $signed(lo_bits[7:0]);
      valid_hi_c = $signed(hi_bits[8:0]);
      hyst_c = int'(hyst) & 'hF;
      base_s = int'(base) & 'h3F;
      settings_applied++;
   endtask

   // result side: long hold-offs on request, otherwise the current stall mode
   always @(posedge clock) begin
      if (holds_asked != holds_served) begin
         hold_left = HOLD_CYCLES;
         holds_served++;
      end
      stall_pattern <= (cycle_count % 64 == 0) ? 8'($urandom)
                                               : {stall_pattern[0], stall_pattern[7:1]};
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (rsp_mode)
            RSP_RANDOM:  rsp_stall <= ($urandom_range(0, 99) < 35);
            RSP_PATTERN: rsp_stall <= stall_pattern[0];
            default:     rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin : check_rsp
      fan_result_type got;
      fan_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_result_status, rsp_fan_speed, rsp_zone_index,
                 rsp_temperature_c, rsp_next_interval_s};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: status %0d speed %0d zone %0d temp %0d ival %0d",
                        got.status, got.speed, got.zone, $signed(got.temp_c), got.interval);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result %0d mismatch: exp status %0d speed %0d zone %0d temp %0d ",
                            "ival %0d, got status %0d speed %0d zone %0d temp %0d ival %0d"},
                           results_checked, want.status, want.speed, want.zone,
                           $signed(want.temp_c), want.interval, got.status, got.speed,
                           got.zone, $signed(got.temp_c), got.interval);
            end
         end
      end
   end

   // default registers: truncation, each zone upward, held band, cooling
   task automatic test_default_curve();
      logic [fzsh_pkg::RAW_W-1:0] raws [$];
      raws = '{13'd0, 13'd8191, 13'd2731, 13'd2732, 13'd3192, 13'd3242, 13'd3292,
               13'd3342, 13'd3392, 13'd3442, 13'd3592, 13'd3742, 13'd3772, 13'd3782,
               13'd3832, 13'd3842, 13'd3722, 13'd3702, 13'd3332, 13'd3322};
      foreach (raws[i])
         send_reading(raws[i]);
   endtask

   // wide window, no hysteresis, zero base interval, minus one degree
   task automatic test_wide_window();
      logic [fzsh_pkg::RAW_W-1:0] raws [$];
      write_limits(-64, 255, 0, 0);
      raws = '{13'd2722, 13'd2713, 13'd2092, 13'd2091, 13'd2082, 13'd5282, 13'd5292,
               13'd3742, 13'd3732, 13'd3722};
      foreach (raws[i])
         send_reading(raws[i]);
   endtask

   // inverted window rejects all; then maximum hysteresis keeps the top speed
   task automatic test_window_extremes();
      write_limits(127, -64, 15, 60);
      send_reading(13'd2732);
      send_reading(13'd4002);
      send_reading(13'd2092);
      write_limits(-64, 127, 15, 60);
      send_reading(13'd3742);
      send_reading(13'd3592);
      send_reading(13'd3582);
   endtask

   // result side holds off while readings keep coming, so the input stalls
   task automatic test_back_pressure();
      write_limits(0, 110, 3, 10);
      sender_gaps = 1'b0;
      rsp_mode = RSP_READY;
      holds_asked++;
      for (int i = 0; i < 40; i++)
         send_reading(raw_for_celsius(40 + int'($urandom_range(0, 75))));
   endtask

   task automatic test_random_walks();
      int pick;
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: write_limits(0, 110, 3, 10);
            1: write_limits(-64, 255, 15, 1);
            2: write_limits(20, 100, 7, 60);
            default: write_limits(int'($urandom_range(0, 100)) - 64,
                                  int'($urandom_range(40, 255)),
                                  $urandom_range(0, 15), $urandom_range(1, 60));
         endcase
         for (int i = 0; i < 240; i++) begin
            if (i % 60 == 0) begin
               rsp_mode = rsp_mode_type'($urandom_range(0, 2));
               sender_gaps = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               if (walk_c < 30)
                  drift = 1;
               else if (walk_c > 112)
                  drift = -1;
               else if ($urandom_range(0, 19) == 0)
                  drift = -drift;
               walk_c = walk_c + drift + int'($urandom_range(0, 4)) - 2;
               send_reading(raw_for_celsius(walk_c));
            end else if (pick < 85) begin
               send_reading(raw_for_celsius((pick[0] ? valid_lo_c : valid_hi_c)
                                            + int'($urandom_range(0, 2)) - 1));
            end else begin
               send_reading(fzsh_pkg::RAW_W'($urandom));
            end
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_default_curve();
      test_wide_window();
      test_window_extremes();
      test_back_pressure();
      test_random_walks();
      wait_all_results();
      $display("%0d readings sent, %0d results checked across %0d register settings",
               readings_sent, results_checked, settings_applied);
      $display("covered zone walks, hysteresis holds, invalid and held readings, back-pressure");
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("fan_zone_speed_hysteresis_core verification clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("fan_zone_speed_hysteresis_core verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
rtl/fzsh_pkg.sv
rtl/fan_zone_speed_hysteresis_core.sv
test/testbench.sv
